FILE: design/rsi_pkg.sv
// Package for the ray-sphere intersection pipeline.
// Holds the fixed widths of the stream fields and data buses.
// No dependencies.
`default_nettype none
package rsi_pkg;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned RADIUS_W = 31;
  localparam int unsigned IN_DATA_W = 8 * COORD_W;
  localparam int unsigned OUT_DATA_W = 40;
endpackage
`default_nettype wire

FILE: design/ray_sphere_intersect.sv
// Ray against origin-centred sphere intersection, geometric method, fixed point.
// Pipeline: 72 register stages (8 arithmetic stages plus a 64-stage bit-serial square
// root pipeline). Throughput: one request per cycle.
// A stall holds every stage; valid bits travel with the data. Reset (rst, synchronous)
// clears all valid bits and sets the radius to 1.0.
// Uses rsi_pkg.
`default_nettype none
module ray_sphere_intersect #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [rsi_pkg::RADIUS_W-1:0] cfg_data,
  input  wire logic s_tvalid,
  output logic s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, range_min, range_max
  input  wire logic [rsi_pkg::IN_DATA_W-1:0] s_tdata,
  output logic m_tvalid,
  input  wire logic m_tready,
  // hit[0], hit_distance[32:1], zero fill
  output logic [rsi_pkg::OUT_DATA_W-1:0] m_tdata
);
  import rsi_pkg::*;

  localparam int unsigned SQ_N = 64;
  localparam int unsigned NST = 8 + SQ_N;

  logic [RADIUS_W-1:0] sphere_radius;
  logic adv;
  logic [NST-1:0] vld;

  assign adv = ~m_tvalid | m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= RADIUS_W'(64'd1 << FRAC_BITS);
      vld <= '0;
    end else begin
      if (cfg_we) sphere_radius <= cfg_data;
      if (adv) vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // Stage 1: the seven products.
  logic signed [63:0] p1 [3];
  logic signed [63:0] o1 [3];
  logic signed [31:0] lo1, hi1;
  logic [61:0] rr1;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1[i] <= $signed(s_tdata[i*32 +: 32]) * $signed(s_tdata[(i+3)*32 +: 32]);
        o1[i] <= $signed(s_tdata[i*32 +: 32]) * $signed(s_tdata[i*32 +: 32]);
      end
      rr1 <= sphere_radius * sphere_radius;
      lo1 <= s_tdata[6*32 +: 32];
      hi1 <= s_tdata[7*32 +: 32];
    end
  end

  // Stage 2: the sums for S (negated) and L2, R2 scaled.
  logic signed [66:0] sneg2;
  logic [65:0] osq2;
  logic [61:0] r2_2;
  logic signed [31:0] lo2, hi2;
  always_ff @(posedge clk) begin
    if (adv) begin
      sneg2 <= -(67'(p1[0]) + 67'(p1[1]) + 67'(p1[2]));
      osq2 <= 66'($unsigned(o1[0])) + 66'($unsigned(o1[1])) + 66'($unsigned(o1[2]));
      r2_2 <= rr1 >> FRAC_BITS;
      lo2 <= lo1; hi2 <= hi1;
    end
  end

  // Stage 3: S (arithmetic shift floors), L2, magnitude of S.
  logic signed [66:0] s3;
  logic [66:0] smag3;
  logic [65:0] l2_3;
  logic [61:0] r2_3;
  logic signed [31:0] lo3, hi3;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3 <= sneg2 >>> FRAC_BITS;
      smag3 <= 67'(sneg2[66] ? -(sneg2 >>> FRAC_BITS) : (sneg2 >>> FRAC_BITS));
      l2_3 <= osq2 >> FRAC_BITS;
      r2_3 <= r2_2; lo3 <= lo2; hi3 <= hi2;
    end
  end

  // Stage 4: S squared in 32-bit partial products.
  logic [63:0] pp4 [3];
  logic signed [66:0] s4;
  logic [65:0] l2_4;
  logic [61:0] r2_4;
  logic signed [31:0] lo4, hi4;
  always_ff @(posedge clk) begin
    if (adv) begin
      pp4[0] <= smag3[31:0] * smag3[31:0];
      pp4[1] <= smag3[31:0] * 64'(smag3[63:32]);
      pp4[2] <= 64'(smag3[63:32]) * 64'(smag3[63:32]);
      s4 <= s3; l2_4 <= l2_3; r2_4 <= r2_3; lo4 <= lo3; hi4 <= hi3;
    end
  end

  // Stage 5: combine, rhs = R2 + floor(S^2 / 2^F).
  logic [131:0] rhs5;
  logic signed [66:0] s5;
  logic [65:0] l2_5;
  logic miss5;
  logic signed [31:0] lo5, hi5;
  always_ff @(posedge clk) begin
    if (adv) begin
      rhs5 <= 132'(r2_4) + ((132'(pp4[0]) + (132'(pp4[1]) << 33)
              + (132'(pp4[2]) << 64)) >> FRAC_BITS);
      s5 <= s4; l2_5 <= l2_4;
      miss5 <= s4[66] && (l2_4 > 66'(r2_4));
      lo5 <= lo4; hi5 <= hi4;
    end
  end

  // Stage 6 fills entry 0 with the miss test and the radicand; the square root then
  // produces one result bit per stage (restoring, remainder form).
  logic [127:0] sq_rem [SQ_N+1];
  logic [63:0]  sq_res [SQ_N+1];
  logic signed [66:0] sq_s [SQ_N+1];
  logic sq_miss [SQ_N+1];
  logic signed [31:0] sq_lo [SQ_N+1];
  logic signed [31:0] sq_hi [SQ_N+1];

  always_ff @(posedge clk) begin
    logic [129:0] trial;
    if (adv) begin
      sq_miss[0] <= miss5 || (132'(l2_5) > rhs5);
      sq_rem[0] <= 128'((rhs5 - 132'(l2_5)) << FRAC_BITS);
      sq_res[0] <= '0;
      sq_s[0] <= s5; sq_lo[0] <= lo5; sq_hi[0] <= hi5;
      for (int g = 0; g < SQ_N; g++) begin
        trial = (130'(sq_res[g]) << (SQ_N - g)) + (130'(1) << (2 * (SQ_N - 1 - g)));
        if (trial <= 130'(sq_rem[g])) begin
          sq_rem[g+1] <= 128'(130'(sq_rem[g]) - trial);
          sq_res[g+1] <= sq_res[g] | (64'd1 << (SQ_N - 1 - g));
        end else begin
          sq_rem[g+1] <= sq_rem[g];
          sq_res[g+1] <= sq_res[g];
        end
        sq_s[g+1] <= sq_s[g];
        sq_miss[g+1] <= sq_miss[g];
        sq_lo[g+1] <= sq_lo[g];
        sq_hi[g+1] <= sq_hi[g];
      end
    end
  end

  // Stage 7: t0 and t1.
  logic signed [68:0] t0_7, t1_7;
  logic miss7;
  logic signed [31:0] lo7, hi7;
  always_ff @(posedge clk) begin
    if (adv) begin
      t0_7 <= 69'(sq_s[SQ_N]) - $signed({5'd0, sq_res[SQ_N]});
      t1_7 <= 69'(sq_s[SQ_N]) + $signed({5'd0, sq_res[SQ_N]});
      miss7 <= sq_miss[SQ_N];
      lo7 <= sq_lo[SQ_N]; hi7 <= sq_hi[SQ_N];
    end
  end

  // Stage 8: range selection, output register.
  logic in0, in1;
  assign in0 = (t0_7 >= 69'(lo7)) && (t0_7 <= 69'(hi7));
  assign in1 = (t1_7 >= 69'(lo7)) && (t1_7 <= 69'(hi7));
  always_ff @(posedge clk) begin
    if (adv) begin
      if (miss7 || (!in0 && !in1)) m_tdata <= '0;
      else if (in0) m_tdata <= {7'd0, t0_7[31:0], 1'b1};
      else m_tdata <= {7'd0, t1_7[31:0], 1'b1};
    end
  end
endmodule
`default_nettype wire
